[sv/assert_macros.svh]
// Assertion macros shared by the arbiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every edge out of reset.
`define APQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define APQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define APQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/apq_pkg.sv]
// Types, constants and helpers of the aging priority queue arbiter.
package apq_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int TRACKS_PER_SIDE = 2;
  localparam int NUM_QUEUES      = 2 * TRACKS_PER_SIDE;
  localparam int MEM_DEPTH       = NUM_QUEUES * QUEUE_DEPTH;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int Q_W     = $clog2(NUM_QUEUES);
  localparam int TRK_W   = (TRACKS_PER_SIDE > 1) ? $clog2(TRACKS_PER_SIDE) : 1;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);
  localparam int PRIO_W  = 2;
  localparam int TAG_W   = 16;
  localparam int SUM_W   = $clog2(3 * (QUEUE_DEPTH - 1) + 1);
  localparam int BONUS_W = 16;
  localparam int SCORE_W = ((SUM_W > BONUS_W) ? SUM_W : BONUS_W) + 1;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_ARB = 1'b1;

  typedef struct packed {
    logic              mode;
    logic              side;
    logic              track;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  item_tag;
  } apq_in_t;

  typedef struct packed {
    logic              accepted;
    logic              granted;
    logic              grant_side;
    logic              grant_track;
    logic [PRIO_W-1:0] grant_priority;
    logic [TAG_W-1:0]  grant_tag;
  } apq_out_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } apq_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_SCAN,
    ST_PICK,
    ST_WB,
    ST_RESP
  } apq_state_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [Q_W-1:0] queue_of(input logic s, input logic [TRK_W-1:0] t);
    return Q_W'(32'(s) * TRACKS_PER_SIDE + 32'(t));
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [Q_W-1:0] q,
                                                 input logic [PTR_W-1:0] p);
    return ADDR_W'(32'(q) * QUEUE_DEPTH + 32'(p));
  endfunction

endpackage

[sv/aging_priority_queue_arbiter.sv]
// Top level of the aging priority queue arbiter: sequencer, queue state and entry store.
//
// Usage:
//   in_valid/in_ready/in_data carry one command beat (apq_in_t). mode 0 enqueues
//   priority_req and item_tag on queue (side, track); mode 1 arbitrates and grants
//   one head across the four ring queues. out_valid/out_ready/out_data return one
//   result beat (apq_out_t) per command.
//   Steps: an enqueue goes from accept through capture, check and write, and
//   load result. An arbitrate has one shared score/compare unit visit one
//   queue per cycle, then picks the winner and reads the entry store, retires
//   the head and loads the result.
//   in_ready is high only while the sequencer sits idle, so one command is in work
//   at a time; a new command is taken only once the last result is loaded.
//   The result register parts the channels: when the receiver stalls, the finished
//   beat holds in the result register and the sequencer waits before loading the
//   next one.
//   Reset (rst_n low, synchronous) empties every queue, clears sums and aging
//   bonuses and drops any pending beat. The entry store needs no clearing pass:
//   only entries that were enqueued are ever read.
module aging_priority_queue_arbiter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  apq_pkg::apq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output apq_pkg::apq_out_t out_data
);
  import apq_pkg::*;

  `include "assert_macros.svh"

  // Sequencer and captured command
  apq_state_t state_r, state_nxt;
  apq_in_t    in_r, in_nxt;

  // Per-queue state
  logic [PTR_W-1:0]   head_r  [NUM_QUEUES];
  logic [PTR_W-1:0]   head_nxt[NUM_QUEUES];
  logic [PTR_W-1:0]   tail_r  [NUM_QUEUES];
  logic [PTR_W-1:0]   tail_nxt[NUM_QUEUES];
  logic [SUM_W-1:0]   sum_r   [NUM_QUEUES];
  logic [SUM_W-1:0]   sum_nxt [NUM_QUEUES];
  logic [BONUS_W-1:0] bonus_r [NUM_QUEUES];
  logic [BONUS_W-1:0] bonus_nxt[NUM_QUEUES];

  // Scan unit: one queue per cycle, best so far per side
  logic               scan_side_r, scan_side_nxt;
  logic [TRK_W-1:0]   scan_trk_r, scan_trk_nxt;
  logic [SCORE_W-1:0] best_score_r  [2];
  logic [SCORE_W-1:0] best_score_nxt[2];
  logic [TRK_W-1:0]   best_trk_r    [2];
  logic [TRK_W-1:0]   best_trk_nxt  [2];
  logic               found_r       [2];
  logic               found_nxt     [2];

  // Grant in flight
  logic [Q_W-1:0]   gq_r, gq_nxt;
  logic             gs_r, gs_nxt;
  logic [TRK_W-1:0] gt_r, gt_nxt;

  // Pending result and output register
  apq_out_t res_r, res_nxt;
  apq_out_t out_r, out_nxt;
  logic     out_valid_r, out_valid_nxt;

  // Entry store
  apq_entry_t        mem [MEM_DEPTH];
  apq_entry_t        rd_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  apq_entry_t        mem_wdata;

  // Scratch for the combinational block
  logic [Q_W-1:0]     eq_q;
  logic               eq_ok;
  logic [Q_W-1:0]     sq;
  logic [SCORE_W-1:0] score;
  logic               pick_side;
  logic [TRK_W-1:0]   pick_trk;
  logic [Q_W-1:0]     pick_q;
  logic [SUM_W-1:0]   rd_prio_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    sum_nxt        = sum_r;
    bonus_nxt      = bonus_r;
    scan_side_nxt  = scan_side_r;
    scan_trk_nxt   = scan_trk_r;
    best_score_nxt = best_score_r;
    best_trk_nxt   = best_trk_r;
    found_nxt      = found_r;
    gq_nxt         = gq_r;
    gs_nxt         = gs_r;
    gt_nxt         = gt_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = '0;
    mem_raddr      = '0;
    mem_wdata      = '0;

    eq_q      = queue_of(in_r.side, TRK_W'(in_r.track));
    eq_ok     = (32'(in_r.track) < TRACKS_PER_SIDE) && (in_r.priority_req != '0) &&
                (ring_next(tail_r[eq_q]) != head_r[eq_q]);
    sq        = queue_of(scan_side_r, scan_trk_r);
    score     = SCORE_W'(sum_r[sq]) + SCORE_W'(bonus_r[sq]);
    pick_side = found_r[1] && (!found_r[0] || (best_score_r[1] > best_score_r[0]));
    pick_trk  = pick_side ? best_trk_r[1] : best_trk_r[0];
    pick_q    = queue_of(pick_side, pick_trk);
    rd_prio_w = SUM_W'(rd_r.prio);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt        = in_data;
          scan_side_nxt = 1'b0;
          scan_trk_nxt  = '0;
          found_nxt[0]  = 1'b0;
          found_nxt[1]  = 1'b0;
          state_nxt     = (in_data.mode == MODE_ARB) ? ST_SCAN : ST_ENQ;
        end
      end

      ST_ENQ: begin
        // Check priority and room, store the item at the tail and grow the sum
        res_nxt          = '0;
        res_nxt.accepted = eq_ok;
        if (eq_ok) begin
          mem_we         = 1'b1;
          mem_waddr      = mem_addr(eq_q, tail_r[eq_q]);
          mem_wdata.prio = in_r.priority_req;
          mem_wdata.tag  = in_r.item_tag;
          tail_nxt[eq_q] = ring_next(tail_r[eq_q]);
          sum_nxt[eq_q]  = sum_r[eq_q] + SUM_W'(in_r.priority_req);
        end
        state_nxt = ST_RESP;
      end

      ST_SCAN: begin
        // Score one queue, age it, and keep the best of its side
        if (head_r[sq] != tail_r[sq]) begin
          if (bonus_r[sq] != '1) begin
            bonus_nxt[sq] = bonus_r[sq] + 1'b1;
          end
          if (!found_r[scan_side_r] || (score > best_score_r[scan_side_r])) begin
            found_nxt[scan_side_r]      = 1'b1;
            best_score_nxt[scan_side_r] = score;
            best_trk_nxt[scan_side_r]   = scan_trk_r;
          end
        end
        if (scan_trk_r == TRK_W'(TRACKS_PER_SIDE - 1)) begin
          scan_trk_nxt  = '0;
          scan_side_nxt = 1'b1;
          if (scan_side_r) begin
            state_nxt = ST_PICK;
          end
        end else begin
          scan_trk_nxt = scan_trk_r + 1'b1;
        end
      end

      ST_PICK: begin
        // Choose the winner and fetch its head entry
        if (!found_r[0] && !found_r[1]) begin
          res_nxt   = '0;
          state_nxt = ST_RESP;
        end else begin
          gq_nxt    = pick_q;
          gs_nxt    = pick_side;
          gt_nxt    = pick_trk;
          mem_re    = 1'b1;
          mem_raddr = mem_addr(pick_q, head_r[pick_q]);
          state_nxt = ST_WB;
        end
      end

      ST_WB: begin
        // Retire the head: drop it, shrink the sum, reset its age
        res_nxt                = '0;
        res_nxt.granted        = 1'b1;
        res_nxt.grant_side     = gs_r;
        res_nxt.grant_track    = gt_r[0];
        res_nxt.grant_priority = rd_r.prio;
        res_nxt.grant_tag      = rd_r.tag;
        sum_nxt[gq_r]   = sum_r[gq_r] - ((rd_prio_w <= sum_r[gq_r]) ? rd_prio_w : sum_r[gq_r]);
        bonus_nxt[gq_r] = '0;
        head_nxt[gq_r]  = ring_next(head_r[gq_r]);
        state_nxt       = ST_RESP;
      end

      ST_RESP: begin
        // Load the result register once it is free
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      scan_side_r <= 1'b0;
      scan_trk_r  <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        sum_r[i]   <= '0;
        bonus_r[i] <= '0;
      end
      for (int s = 0; s < 2; s++) begin
        found_r[s] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      scan_side_r <= scan_side_nxt;
      scan_trk_r  <= scan_trk_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      sum_r       <= sum_nxt;
      bonus_r     <= bonus_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r         <= in_nxt;
    best_score_r <= best_score_nxt;
    best_trk_r   <= best_trk_nxt;
    gq_r         <= gq_nxt;
    gs_r         <= gs_nxt;
    gt_r         <= gt_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  `APQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, state_r != ST_IDLE,
    "sequencer stayed idle after accepting a command beat")
  `APQ_ASSERT_NEXT(a_scan_to_pick, state_r == ST_SCAN && scan_side_r &&
    scan_trk_r == TRK_W'(TRACKS_PER_SIDE - 1), state_r == ST_PICK,
    "scan did not end after the last queue")
  `APQ_ASSERT_NEXT(a_bonus_cleared, state_r == ST_WB, bonus_r[gq_r] == '0,
    "aging bonus of the granted queue not cleared")
  `APQ_ASSERT_NOW(a_grant_prio, out_valid_r && out_r.granted,
    out_r.grant_priority != '0 && !out_r.accepted,
    "granted beat carries zero priority or an enqueue flag")

endmodule

[tb/sv/aging_priority_queue_arbiter_tb.sv]
// Self-checking testbench for the aging priority queue arbiter.
module aging_priority_queue_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apq_pkg::*;

  // Random part of the stimulus, in command beats.
  localparam int RANDOM_CMDS = 1250;
  // Receiver hold-off: start after this many result beats, hold this long.
  localparam int HOLD_AT_RESULT = 300;
  localparam int HOLD_CYCLES    = 400;
  // Watchdog: cycles with no beat on either channel before giving up.
  localparam int STALL_LIMIT = 4000;
  // Quiet cycles after the last expected result.
  localparam int DRAIN_CYCLES = 24;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  apq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  apq_out_t out_data;

  aging_priority_queue_arbiter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Commands waiting to be offered, and results owed by the block in order.
  apq_in_t  command_backlog [$];
  apq_out_t awaited_results [$];

  int unsigned total_cmds = 0;
  int unsigned issued_count = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Predicted queue state. Every queue is a ring with one slot kept free; the
  // sum and the aging bonus travel with the queue, not with its entries.
  // ---------------------------------------------------------------------------
  logic [PRIO_W-1:0]  prio_mem   [NUM_QUEUES][QUEUE_DEPTH];
  logic [TAG_W-1:0]   tag_mem    [NUM_QUEUES][QUEUE_DEPTH];
  logic [PTR_W-1:0]   rd_ptr     [NUM_QUEUES] = '{default: '0};
  logic [PTR_W-1:0]   wr_ptr     [NUM_QUEUES] = '{default: '0};
  logic [SUM_W-1:0]   weight_sum [NUM_QUEUES] = '{default: '0};
  logic [BONUS_W-1:0] age        [NUM_QUEUES] = '{default: '0};

  // Apply one command to the predicted state and return the beat it owes.
  function automatic apq_out_t arbiter_outcome(apq_in_t cmd);
    apq_out_t         res;
    logic [PTR_W-1:0] nxt;
    int               best_score [2];
    int               best_track [2];
    bit               seen [2];
    int               score, qi, s, t, gs, gt;
    res = '0;
    if (cmd.mode == MODE_ENQ) begin
      // Drop a zero priority, a track beyond the side, or a full ring.
      if (int'(cmd.track) >= TRACKS_PER_SIDE || cmd.priority_req == '0) return res;
      qi = int'(cmd.side) * TRACKS_PER_SIDE + int'(cmd.track);
      nxt = (wr_ptr[qi] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr[qi] + 1'b1;
      if (nxt == rd_ptr[qi]) return res;
      prio_mem[qi][wr_ptr[qi]] = cmd.priority_req;
      tag_mem[qi][wr_ptr[qi]]  = cmd.item_tag;
      wr_ptr[qi] = nxt;
      weight_sum[qi] = weight_sum[qi] + cmd.priority_req;
      res.accepted = 1'b1;
      return res;
    end
    // Score every non-empty queue, then age it; lower track wins a tie.
    for (s = 0; s < 2; s++) begin
      seen[s] = 1'b0;
      best_score[s] = 0;
      best_track[s] = 0;
      for (t = 0; t < TRACKS_PER_SIDE; t++) begin
        qi = s * TRACKS_PER_SIDE + t;
        if (rd_ptr[qi] == wr_ptr[qi]) continue;
        score = int'(weight_sum[qi]) + int'(age[qi]);
        if (age[qi] != '1) age[qi] = age[qi] + 1'b1;
        if (!seen[s] || score > best_score[s]) begin
          seen[s] = 1'b1;
          best_score[s] = score;
          best_track[s] = t;
        end
      end
    end
    if (!seen[0] && !seen[1]) return res;
    // Right side needs a strictly better score to take the grant.
    if (seen[1] && (!seen[0] || best_score[1] > best_score[0])) begin
      gs = 1;
    end else begin
      gs = 0;
    end
    gt = best_track[gs];
    qi = gs * TRACKS_PER_SIDE + gt;
    res.granted        = 1'b1;
    res.grant_side     = gs[0];
    res.grant_track    = gt[0];
    res.grant_priority = prio_mem[qi][rd_ptr[qi]];
    res.grant_tag      = tag_mem[qi][rd_ptr[qi]];
    if (prio_mem[qi][rd_ptr[qi]] <= weight_sum[qi]) begin
      weight_sum[qi] = weight_sum[qi] - prio_mem[qi][rd_ptr[qi]];
    end else begin
      weight_sum[qi] = '0;
    end
    age[qi] = '0;
    rd_ptr[qi] = (rd_ptr[qi] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr[qi] + 1'b1;
    return res;
  endfunction

  function automatic void check_field(string name, logic [TAG_W-1:0] want,
                                      logic [TAG_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic stage_command(logic mode, logic side, logic track,
                               logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
    apq_in_t c;
    c.mode         = mode;
    c.side         = side;
    c.track        = track;
    c.priority_req = prio;
    c.item_tag     = tag;
    command_backlog.push_back(c);
  endtask

  // ---------------------------------------------------------------------------
  // Idle pattern by progress through the run: sender idles 30% and receiver
  // 79% first, then the other way round, then a stretch with no idling.
  // ---------------------------------------------------------------------------
  int unsigned tx_idle_pct, rx_idle_pct;
  always_comb begin
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    if (total_cmds != 0) begin
      case ((issued_count * 3) / total_cmds)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 79;
        end
        1: begin
          tx_idle_pct = 79;
          rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: predict at the accepting edge, then offer the next command or
  // drop valid. Valid is only touched once the current beat is gone.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(arbiter_outcome(in_data));
        issued_count <= issued_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (command_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= command_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest expectation and drive
  // out_ready. Once, hold ready low long enough for the block to back up
  // into in_ready while the driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    apq_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          $error("result beat with no command awaiting it: %0h", out_data);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("accepted", TAG_W'(want.accepted), TAG_W'(out_data.accepted));
          check_field("granted", TAG_W'(want.granted), TAG_W'(out_data.granted));
          check_field("grant_side", TAG_W'(want.grant_side),
                      TAG_W'(out_data.grant_side));
          check_field("grant_track", TAG_W'(want.grant_track),
                      TAG_W'(out_data.grant_track));
          check_field("grant_priority", TAG_W'(want.grant_priority),
                      TAG_W'(out_data.grant_priority));
          check_field("grant_tag",      want.grant_tag,      out_data.grant_tag);
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: any beat on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("aging_priority_queue_arbiter_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned       n, len, i, kind;
    logic              fix_side, fix_track;
    logic [PRIO_W-1:0] prio;
    logic              mode;

    // Directed: arbitrate with every queue empty, garbage in the unused fields.
    stage_command(MODE_ARB, 1'b1, 1'b1, 2'd3, 16'hFFFF);
    // Zero priority is refused.
    stage_command(MODE_ENQ, 1'b0, 1'b0, 2'd0, 16'h1234);
    // Fill the right side's second track to its last usable slot.
    for (i = 0; i < QUEUE_DEPTH - 1; i++) begin
      stage_command(MODE_ENQ, 1'b1, 1'b1, PRIO_W'(i % 3 + 1),
                    (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(i * 16'h1111));
    end
    // One more on the full ring is refused.
    stage_command(MODE_ENQ, 1'b1, 1'b1, 2'd3, 16'hA5A5);
    // One item on each other queue, then grant a few heads.
    stage_command(MODE_ENQ, 1'b0, 1'b0, 2'd1, 16'h5A5A);
    stage_command(MODE_ENQ, 1'b0, 1'b1, 2'd2, 16'h00FF);
    stage_command(MODE_ENQ, 1'b1, 1'b0, 2'd3, 16'hFF00);
    stage_command(MODE_ARB, 1'b0, 1'b0, 2'd0, 16'h0000);
    stage_command(MODE_ARB, 1'b0, 1'b1, 2'd1, 16'h8001);
    stage_command(MODE_ARB, 1'b1, 1'b0, 2'd2, 16'h7FFE);

    // Random: bursts of enqueues (sometimes hammering one queue until it is
    // full), bursts of arbitrations that drain toward empty, and mixed runs.
    n = 0;
    while (n < RANDOM_CMDS) begin
      kind      = $urandom_range(9);
      len       = $urandom_range(1, 24);
      fix_side  = 1'($urandom_range(1));
      fix_track = 1'($urandom_range(1));
      for (i = 0; i < len && n < RANDOM_CMDS; i++) begin
        if (kind < 4) begin
          mode = ($urandom_range(9) == 0) ? MODE_ARB : MODE_ENQ;
        end else if (kind < 7) begin
          mode = ($urandom_range(9) == 0) ? MODE_ENQ : MODE_ARB;
        end else begin
          mode = $urandom_range(1) ? MODE_ARB : MODE_ENQ;
        end
        prio = ($urandom_range(19) == 0) ? 2'd0 : PRIO_W'($urandom_range(1, 3));
        if (kind < 2) begin
          stage_command(mode, fix_side, fix_track, prio, 16'($urandom));
        end else begin
          stage_command(mode, 1'($urandom), 1'($urandom), prio, 16'($urandom));
        end
        n++;
      end
    end
    total_cmds = command_backlog.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every command is taken, then until every result is back.
    while (issued_count < total_cmds) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("aging_priority_queue_arbiter_tb OK");
    end else begin
      $display("aging_priority_queue_arbiter_tb NOT OK");
    end
    $finish;
  end

endmodule
